>>> rtl/dsg_pkg.sv
// shared types, constants and sine table builder for the decaying sine generator
package dsg_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_SINE_TABLE_DEPTH = 256;
    localparam int DEF_PHASE_BITS       = 24;

    // field and register widths
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 15;
    localparam int AMP_W      = 15;
    localparam int FRAME_W    = 24;
    localparam int ENV_W      = 24;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // fixed-point constants
    localparam int MAG_SHIFT = 38;
    localparam int ENV_FRAC  = 24;
    localparam logic [MAG_W-1:0]  FULL_SCALE = 15'h7FFF;
    localparam logic [ENV_W-1:0]  ENV_ONE    = 24'h80_0000;
    localparam logic [PROD_W-1:0] ENV_ROUND  = PROD_W'(64'd1 << (ENV_FRAC - 1));
    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;

    // configuration register reset values
    localparam logic [CFG_DATA_W-1:0] RST_PHASE_STEP   = 24'd0;
    localparam logic [AMP_W-1:0]      RST_AMPLITUDE    = 15'h7FFF;
    localparam logic [CFG_DATA_W-1:0] RST_DECAY_FACTOR = 24'hFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] RST_SAMPLE_COUNT = 24'd48000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP   = 2'd0,
        CFG_AMPLITUDE    = 2'd1,
        CFG_DECAY_FACTOR = 2'd2,
        CFG_SAMPLE_COUNT = 2'd3
    } cfg_reg_t;

    // signed sine value as sign and magnitude
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sine_val_t;

    // quarter-wave entry: truncating q2.30 taylor series through x^13
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
                                                    input int unsigned qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned scaled;
        longint          sum;
        x    = (HALF_PI_Q30 * longint'(k)) >> qbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = (term * x2) >> 30;
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                default: term = term / 156;
            endcase
            if ((n & 1) != 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        scaled = ((longint'(sum) * 32767) + (64'd1 << 29)) >> 30;
        return scaled[MAG_W-1:0];
    endfunction

endpackage

>>> rtl/dsg_sine_rom.sv
// quarter-wave sine rom with quadrant folding and registered read
module dsg_sine_rom
    import dsg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
    parameter int PHASE_BITS       = DEF_PHASE_BITS
)
(
    input  logic                  clk,
    input  logic [PHASE_BITS-1:0] phase,
    output sine_val_t             sine
);

    // largest power of two not above the table depth
    localparam int DEPTH_LOG = $clog2(SINE_TABLE_DEPTH);
    localparam int QBITS     = ((1 << DEPTH_LOG) == SINE_TABLE_DEPTH) ? DEPTH_LOG
                                                                     : DEPTH_LOG - 1;
    localparam int QDEPTH    = 1 << QBITS;

    logic [1:0]       quad;
    logic [QBITS-1:0] idx;
    logic [QBITS-1:0] rd_addr;
    logic [MAG_W-1:0] rom_table [QDEPTH];
    logic [MAG_W-1:0] rom_q_reg;
    logic             neg_reg;
    logic             peak_pt_reg;

    // constant table contents
    for (genvar k = 0; k < QDEPTH; k++) begin : g_rom
        assign rom_table[k] = sine_entry(k, QBITS);
    end

    // quadrant and index from the top phase bits, mirrored in odd quadrants
    assign quad    = phase[PHASE_BITS-1 -: 2];
    assign idx     = phase[PHASE_BITS-3 -: QBITS];
    assign rd_addr = quad[0] ? (~idx + QBITS'(1)) : idx;

    // registered read
    always_ff @(posedge clk)
    begin
        rom_q_reg   <= rom_table[rd_addr];
        neg_reg     <= quad[1];
        peak_pt_reg <= quad[0] && (idx == '0);
    end

    // the quarter-turn point reads full scale
    assign sine.neg = neg_reg;
    assign sine.mag = peak_pt_reg ? FULL_SCALE : rom_q_reg;

endmodule

>>> rtl/dsg_mul.sv
// shared unsigned multiplier with registered product
module dsg_mul
    import dsg_pkg::*;
(
    input  logic               clk,
    input  logic               load,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [PROD_W-1:0]  prod
);

    logic [PROD_W-1:0] prod_reg;

    // one product per cycle when loaded, held otherwise
    always_ff @(posedge clk)
    begin
        if (load)
            prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

>>> rtl/decaying_sine_generator_core.sv
// top level: sequencer, state and output register of the decaying sine generator
//
// Usage
//   Input channel (in_valid / in_stall / restart): one request per sample tick.
//   A request with restart high clears phase, envelope, frame and peak and
//   starts a tone; a request with restart low produces the next sample of a
//   running tone, or nothing once the tone has ended.
//   Output channel (out_valid / out_stall): sample, peak_value, peak_frame and
//   last, one result per request that produces a sample.
//   Configuration (cfg_write_en / cfg_index / cfg_data) is written while idle.
// Timing
//   A producing request runs from acceptance to result as follows: the rom read
//   happens at the accepting edge, then three passes through the shared
//   multiplier (sine by amplitude, by envelope, then envelope by decay), then
//   the output register load.
//   in_stall is high during that work, so no new request is taken until the result is loaded.
//   A request that produces nothing is absorbed in its accepting cycle.
// Reset and stall
//   rst_n clears the state, loads register defaults and leaves the tone stopped.
//   While out_stall holds a result, the next request is still accepted; its
//   final step waits until the output register is free.
module decaying_sine_generator_core
    import dsg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
    parameter int PHASE_BITS       = DEF_PHASE_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write port
    input  logic                        cfg_write_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    // request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        restart,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [SAMPLE_W-1:0]  sample,
    output logic [MAG_W-1:0]            peak_value,
    output logic [FRAME_W-1:0]          peak_frame,
    output logic                        last
);

    localparam int SUM_W = (PHASE_BITS > CFG_DATA_W) ? PHASE_BITS : CFG_DATA_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_AMP   = 5'b00010,
        ST_ENV   = 5'b00100,
        ST_DECAY = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [CFG_DATA_W-1:0]        phase_step_reg;
    logic [AMP_W-1:0]             amplitude_reg;
    logic [CFG_DATA_W-1:0]        decay_reg;
    logic [CFG_DATA_W-1:0]        count_reg;
    logic [PHASE_BITS-1:0]        phase_reg, phase_next;
    logic [ENV_W-1:0]             env_reg, env_next;
    logic [FRAME_W-1:0]           frame_reg, frame_next;
    logic [MAG_W-1:0]             peak_reg, peak_next;
    logic [FRAME_W-1:0]           pos_reg, pos_next;
    logic                         running_reg, running_next;
    logic [MAG_W-1:0]             mag_reg, mag_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0]   sample_reg, sample_next;
    logic [MAG_W-1:0]             peak_out_reg, peak_out_next;
    logic [FRAME_W-1:0]           frame_out_reg, frame_out_next;
    logic                         last_reg, last_next;

    sine_val_t                    sine;
    logic                         mul_load;
    logic [MUL_A_W-1:0]           mul_a;
    logic [MUL_B_W-1:0]           mul_b;
    logic [PROD_W-1:0]            prod;

    logic [SUM_W-1:0]             phase_sum;
    logic [SAMPLE_W-1:0]          prod_mag;
    logic [PROD_W-1:0]            env_sum;
    logic [CFG_DATA_W-1:0]        count_eff;
    logic [FRAME_W:0]             frame_inc;
    logic                         is_last;
    logic                         peak_hit;
    logic signed [SAMPLE_W-1:0]   mag_s;

    // sine lookup follows the phase as it will stand once the request is taken
    dsg_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_rom (
        .clk   (clk),
        .phase (phase_next),
        .sine  (sine)
    );

    dsg_mul u_mul (
        .clk  (clk),
        .load (mul_load),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // datapath helpers
    assign phase_sum = SUM_W'(phase_reg) + SUM_W'(phase_step_reg);
    assign prod_mag  = prod[MAG_SHIFT +: SAMPLE_W];
    assign env_sum   = prod + ENV_ROUND;
    assign count_eff = (count_reg == '0) ? CFG_DATA_W'(1) : count_reg;
    assign frame_inc = {1'b0, frame_reg} + (FRAME_W + 1)'(1);
    assign is_last   = frame_inc >= (FRAME_W + 1)'(count_eff);
    assign peak_hit  = mag_reg > peak_reg;
    assign mag_s     = {1'b0, mag_reg};

    // sequencer and next state
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        env_next       = env_reg;
        frame_next     = frame_reg;
        peak_next      = peak_reg;
        pos_next       = pos_reg;
        running_next   = running_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg && out_stall;
        sample_next    = sample_reg;
        peak_out_next  = peak_out_reg;
        frame_out_next = frame_out_reg;
        last_next      = last_reg;
        mul_load       = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart)
                    begin
                        phase_next   = '0;
                        env_next     = ENV_ONE;
                        frame_next   = '0;
                        peak_next    = '0;
                        pos_next     = '0;
                        running_next = 1'b1;
                        state_next   = ST_AMP;
                    end
                    else if (running_reg)
                    begin
                        state_next = ST_AMP;
                    end
                end
            end
            ST_AMP:
            begin
                // sine magnitude times amplitude
                mul_load   = 1'b1;
                mul_a      = MUL_A_W'(sine.mag);
                mul_b      = MUL_B_W'(amplitude_reg);
                state_next = ST_ENV;
            end
            ST_ENV:
            begin
                // then times envelope
                mul_load   = 1'b1;
                mul_a      = prod[MUL_A_W-1:0];
                mul_b      = env_reg;
                state_next = ST_DECAY;
            end
            ST_DECAY:
            begin
                // saturate the magnitude, start the envelope update
                mag_next   = (prod_mag > SAMPLE_W'(FULL_SCALE)) ? FULL_SCALE
                                                                : prod_mag[MAG_W-1:0];
                mul_load   = 1'b1;
                mul_a      = MUL_A_W'(env_reg);
                mul_b      = decay_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // commit once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = sine.neg ? -mag_s : mag_s;
                    if (peak_hit)
                    begin
                        peak_next = mag_reg;
                        pos_next  = frame_reg;
                    end
                    peak_out_next  = peak_hit ? mag_reg : peak_reg;
                    frame_out_next = peak_hit ? frame_reg : pos_reg;
                    last_next      = is_last;
                    env_next       = env_sum[ENV_FRAC +: ENV_W];
                    phase_next     = phase_sum[PHASE_BITS-1:0];
                    if (is_last)
                        running_next = 1'b0;
                    else
                        frame_next = frame_inc[FRAME_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and tone state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            env_reg       <= ENV_ONE;
            frame_reg     <= '0;
            peak_reg      <= '0;
            pos_reg       <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            env_reg       <= env_next;
            frame_reg     <= frame_next;
            peak_reg      <= peak_next;
            pos_reg       <= pos_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= RST_PHASE_STEP;
            amplitude_reg  <= RST_AMPLITUDE;
            decay_reg      <= RST_DECAY_FACTOR;
            count_reg      <= RST_SAMPLE_COUNT;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PHASE_STEP:   phase_step_reg <= cfg_data;
                CFG_AMPLITUDE:    amplitude_reg  <= cfg_data[AMP_W-1:0];
                CFG_DECAY_FACTOR: decay_reg      <= cfg_data;
                CFG_SAMPLE_COUNT: count_reg      <= cfg_data;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        sample_reg    <= sample_next;
        peak_out_reg  <= peak_out_next;
        frame_out_reg <= frame_out_next;
        last_reg      <= last_next;
    end

    // ports
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample     = sample_reg;
    assign peak_value = peak_out_reg;
    assign peak_frame = frame_out_reg;
    assign last       = last_reg;

endmodule

>>> rtl/dsg_checker.sv
// port-level checks for the decaying sine generator, bound to the top level
module dsg_checker
    import dsg_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       restart,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [SAMPLE_W-1:0] sample,
    input logic [MAG_W-1:0]           peak_value,
    input logic                       last
);

    logic [SAMPLE_W-1:0] sample_abs;

    assign sample_abs = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);

    // a restart request always starts work
    a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && restart |=> in_stall)
        else $error("restart request did not start work");

    // a new result only appears at the end of work
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work in progress");

    // the peak never falls below the sample it reports with
    a_peak_covers_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample_abs <= SAMPLE_W'(peak_value)))
        else $error("peak below current sample magnitude");

    // a stalled result holds its sample and last flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample) && $stable(last))
        else $error("stalled result changed");

endmodule

bind decaying_sine_generator_core dsg_checker u_dsg_checker (.*);

>>> dv/decaying_sine_generator_core_test.sv
// self-checking testbench for the decaying sine generator core
`timescale 1ns / 1ps

module decaying_sine_generator_core_test;
    import dsg_pkg::*;

    localparam int PH_W      = DEF_PHASE_BITS;
    localparam int QTR_BITS  = $clog2(DEF_SINE_TABLE_DEPTH + 1) - 1;
    localparam int QTR       = 1 << QTR_BITS;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int RUN_LIMIT = 400000;
    localparam int HOLD_LEN  = 300;
    localparam int WANT_SAMPLES = 340;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [MAG_W-1:0]           peak;
        logic [FRAME_W-1:0]         frame;
        logic                       last;
    } tone_result_t;

    // clock, reset and block ports
    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       restart = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;
    logic [MAG_W-1:0]           peak_value;
    logic [FRAME_W-1:0]         peak_frame;
    logic                       last;

    // request and sample stores
    bit           pending_restarts[$];
    tone_result_t awaited_samples[$];
    bit           sending = 1'b0;

    // pacing controls
    bit          idling_on = 1'b1;
    int unsigned hold_asked = 0;
    int unsigned hold_served = 0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          send_gap = 0;
    int          cycles = 0;

    // predictor copy of registers and tone state
    logic [CFG_DATA_W-1:0] step_cfg;
    logic [AMP_W-1:0]      amp_cfg;
    logic [CFG_DATA_W-1:0] decay_cfg;
    logic [CFG_DATA_W-1:0] count_cfg;
    logic [PH_W-1:0]       tone_phase;
    logic [ENV_W-1:0]      env;
    logic [FRAME_W-1:0]    frame;
    logic [MAG_W-1:0]      peak_mag;
    logic [FRAME_W-1:0]    peak_at;
    bit                    tone_on;
    logic [MAG_W-1:0]      sine_quarter [QTR];

    // statistics
    int mismatches = 0;
    int results_due = 0;
    int samples_checked = 0;
    int restarts_sent = 0;
    int tones_ended = 0;
    int regs_written = 0;
    int phases = 0;

    decaying_sine_generator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample       (sample),
        .peak_value   (peak_value),
        .peak_frame   (peak_frame),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // quarter-wave entry from a truncating taylor series of sin
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned part;
        longint          acc;
        ang    = (QUARTER_TURN_Q30 * k) / QTR;
        ang_sq = (ang * ang) >> 30;
        part   = ang;
        acc    = ang;
        for (int n = 1; n <= 6; n++)
        begin
            part = ((part * ang_sq) >> 30) / ((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - part : acc + part;
        end
        if (acc < 0)
            acc = 0;
        return MAG_W'(((acc * 32767) + (64'd1 << 29)) >> 30);
    endfunction

    // signed sine for a phase: quadrant from the top bits, mirrored reads
    function automatic int wave_at(input logic [PH_W-1:0] ph);
        logic [1:0]  quad;
        int unsigned idx;
        int          v;
        quad = ph[PH_W-1 -: 2];
        idx  = ph[PH_W-3 -: QTR_BITS];
        if (quad[0])
            v = (idx == 0) ? 32767 : sine_quarter[(QTR - idx) % QTR];
        else
            v = sine_quarter[idx];
        return quad[1] ? -v : v;
    endfunction

    // one accepted request: update the tone and queue the sample it yields
    task automatic predict_tone_step(input logic rs);
        tone_result_t    r;
        int              s;
        int              smp;
        longint unsigned prod;
        logic [MAG_W-1:0] m;
        int unsigned     lim;
        if (rs)
        begin
            tone_phase = '0;
            env        = ENV_ONE;
            frame      = '0;
            peak_mag   = '0;
            peak_at    = '0;
            tone_on    = 1'b1;
            restarts_sent++;
        end
        if (tone_on)
        begin
            s    = wave_at(tone_phase);
            prod = (s < 0) ? -s : s;
            prod = prod * amp_cfg;
            prod = (prod * env) >> 38;
            m    = (prod > 32767) ? 15'h7FFF : prod[MAG_W-1:0];
            smp  = (s < 0) ? -int'(m) : int'(m);
            // equal magnitude keeps the earlier frame
            if (m > peak_mag)
            begin
                peak_mag = m;
                peak_at  = frame;
            end
            lim      = (count_cfg == 0) ? 1 : count_cfg;
            r.sample = smp[SAMPLE_W-1:0];
            r.peak   = peak_mag;
            r.frame  = peak_at;
            r.last   = (frame + 1) >= lim;
            awaited_samples.push_back(r);
            results_due++;
            // envelope decays with round-half-up, phase wraps
            prod       = env;
            prod       = (prod * decay_cfg + 64'h80_0000) >> 24;
            env        = prod[ENV_W-1:0];
            tone_phase = tone_phase + step_cfg;
            if (r.last)
            begin
                tone_on = 1'b0;
                tones_ended++;
            end
            else
                frame = frame + 1'b1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // wait until no request is queued or held and no sample is outstanding
    task automatic settle();
        while (pending_restarts.size() != 0 || sending || awaited_samples.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // write the selected registers back to back, block idle
    task automatic program_tone(input logic [3:0] which, input logic [23:0] step,
                                input logic [23:0] amp, input logic [23:0] decay,
                                input logic [23:0] count);
        logic [23:0] vals [4];
        vals = '{step, amp, decay, count};
        @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            if (which[i])
            begin
                cfg_write_en <= 1'b1;
                cfg_index    <= cfg_reg_t'(i);
                cfg_data     <= vals[i];
                @(posedge clk);
                regs_written++;
                case (cfg_reg_t'(i))
                    CFG_PHASE_STEP:   step_cfg  = vals[i];
                    CFG_AMPLITUDE:    amp_cfg   = vals[i][AMP_W-1:0];
                    CFG_DECAY_FACTOR: decay_cfg = vals[i];
                    CFG_SAMPLE_COUNT: count_cfg = vals[i];
                endcase
            end
        end
        cfg_write_en <= 1'b0;
    endtask

    // random register value biased towards the extremes
    function automatic logic [23:0] pick_word(input int w);
        logic [23:0] r;
        r = 24'($urandom());
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 24'((64'd1 << w) - 1);
            default: return r & 24'((64'd1 << w) - 1);
        endcase
    endfunction

    // request driver: holds a request until taken, idles in bursts
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic nv;
        logic nr;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            restart  <= 1'b0;
            send_gap <= 0;
            sending  = 1'b0;
        end
        else
        begin
            nv = in_valid;
            nr = restart;
            if (in_valid && !in_stall)
            begin
                predict_tone_step(restart);
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (idling_on && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(0, 16);
                else if (pending_restarts.size() != 0)
                begin
                    nv = 1'b1;
                    nr = pending_restarts.pop_front();
                end
            end
            sending  = nv;
            in_valid <= nv;
            restart  <= nr;
        end
    end

    // result side stall: random bursts plus an occasional long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            hold_left   <= 0;
            stall_left  <= 0;
            hold_served <= 0;
        end
        else if (hold_asked != hold_served)
        begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_LEN;
            out_stall   <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // sample monitor against the oldest awaited sample
    always @(posedge clk)
    begin : monitor
        tone_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_samples.size() == 0)
                report_mismatch($sformatf("sample %0d arrived with none awaited", sample));
            else
            begin
                want = awaited_samples.pop_front();
                if (sample !== want.sample)
                    report_mismatch($sformatf("#%0d sample got %0d want %0d",
                                              samples_checked, sample, want.sample));
                if (peak_value !== want.peak)
                    report_mismatch($sformatf("#%0d peak_value got %0d want %0d",
                                              samples_checked, peak_value, want.peak));
                if (peak_frame !== want.frame)
                    report_mismatch($sformatf("#%0d peak_frame got %0d want %0d",
                                              samples_checked, peak_frame, want.frame));
                if (last !== want.last)
                    report_mismatch($sformatf("#%0d last got %0b want %0b",
                                              samples_checked, last, want.last));
            end
            samples_checked++;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT)
        begin
            $display("run stopped: no completion within %0d cycles", RUN_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus: directed tones, then random tones and noise
    initial
    begin : stimulus
        logic [3:0]  which;
        logic [23:0] step_v;
        logic [23:0] amp_v;
        logic [23:0] decay_v;
        logic [23:0] count_v;
        int unsigned n_eff;
        for (int k = 0; k < QTR; k++)
            sine_quarter[k] = quarter_sine(k);
        step_cfg   = RST_PHASE_STEP;
        amp_cfg    = RST_AMPLITUDE;
        decay_cfg  = RST_DECAY_FACTOR;
        count_cfg  = RST_SAMPLE_COUNT;
        tone_phase = '0;
        env        = ENV_ONE;
        frame      = '0;
        peak_mag   = '0;
        peak_at    = '0;
        tone_on    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // idle request ignored, then a tone at the reset settings
        pending_restarts = '{1'b0, 1'b1, 1'b0, 1'b0};
        settle();
        // quarter-turn steps: full-scale peaks of equal size, tone ends
        program_tone(4'hF, 24'h40_0000, 24'h7FFF, 24'hFF_FFFF, 24'd6);
        pending_restarts = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
        settle();
        // zero count acts as one, zero amplitude, largest step
        program_tone(4'hF, 24'hFF_FFFF, 24'h0, 24'h0, 24'd0);
        pending_restarts = '{1'b1, 1'b0};
        settle();
        // restart while running, envelope killed by zero decay
        program_tone(4'hF, 24'h12_3456, 24'h7FFF, 24'h0, 24'd20);
        pending_restarts = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
        settle();
        // count lowered to the current frame
        program_tone(4'b1000, 24'd0, 24'd0, 24'd0, 24'd2);
        pending_restarts = '{1'b0, 1'b0};
        settle();
        // registers changed in the middle of a tone
        program_tone(4'hF, 24'h01_0000, 24'h4000, 24'hFF_F000, 24'd10);
        pending_restarts = '{1'b1, 1'b0, 1'b0};
        settle();
        program_tone(4'b0111, 24'hC0_0001, 24'h7FFF, 24'h80_0000, 24'd0);
        pending_restarts = '{1'b0, 1'b0};

        while (results_due < WANT_SAMPLES)
        begin
            phases++;
            settle();
            // quiet stretches, and no idling at all near the end
            if (results_due > WANT_SAMPLES - 70)
                idling_on <= 1'b0;
            else
                idling_on <= ($urandom_range(0, 3) != 0);
            which   = (phases == 1) ? 4'hF : 4'($urandom_range(0, 15));
            step_v  = pick_word(24);
            amp_v   = pick_word(AMP_W);
            case ($urandom_range(0, 5))
                0:       decay_v = 24'h0;
                1:       decay_v = 24'hFF_FFFF;
                2:       decay_v = 24'($urandom());
                default: decay_v = 24'hF0_0000 | 24'($urandom_range(0, 24'h0F_FFFF));
            endcase
            case ($urandom_range(0, 19))
                0:       count_v = 24'd0;
                1:       count_v = 24'hFF_FFFF;
                2:       count_v = 24'($urandom());
                default: count_v = 24'($urandom_range(1, 24));
            endcase
            if (phases == 6)
            begin
                which[3] = 1'b1;
                count_v  = 24'hFF_FFFF;
            end
            program_tone(which, step_v, amp_v, decay_v, count_v);
            n_eff = (count_cfg == 0) ? 1 : ((count_cfg > 40) ? 40 : count_cfg);
            if (phases == 6)
            begin
                // long result hold while requests keep coming
                hold_asked <= hold_asked + 1;
                pending_restarts.push_back(1'b1);
                repeat (40) pending_restarts.push_back(1'b0);
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0, 1:
                    begin
                        repeat ($urandom_range(1, 12))
                            pending_restarts.push_back($urandom_range(0, 3) == 0);
                    end
                    2:
                    begin
                        // tone cut short by a fresh restart
                        pending_restarts.push_back(1'b1);
                        repeat ($urandom_range(0, n_eff - 1)) pending_restarts.push_back(1'b0);
                        pending_restarts.push_back(1'b1);
                        repeat ($urandom_range(0, 5)) pending_restarts.push_back(1'b0);
                    end
                    default:
                    begin
                        pending_restarts.push_back(1'b1);
                        repeat (n_eff - 1) pending_restarts.push_back(1'b0);
                        repeat ($urandom_range(0, 2)) pending_restarts.push_back(1'b0);
                    end
                endcase
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (awaited_samples.size() != 0)
            report_mismatch($sformatf("%0d samples never arrived", awaited_samples.size()));
        $display("checked %0d samples: %0d restarts, %0d tones run to their last sample",
                 samples_checked, restarts_sent, tones_ended);
        $display("%0d register writes over %0d random settings, %0d mismatches",
                 regs_written, phases, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
rtl/dsg_pkg.sv
rtl/dsg_sine_rom.sv
rtl/dsg_mul.sv
rtl/decaying_sine_generator_core.sv
rtl/dsg_checker.sv
dv/decaying_sine_generator_core_test.sv
